// ===== rtl/ifhg_pkg.sv =====
`default_nettype none

package ifhg_pkg;

    // One send request.
    typedef struct packed {
        logic [15:0] payload_length;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  protocol_number;
    } t_req;

    // One header description, or the error result.
    typedef struct packed {
        logic        too_large;
        logic [15:0] identification;
        logic [15:0] total_length;
        logic        more_fragments;
        logic [12:0] fragment_offset;
        logic [15:0] header_checksum;
        logic [15:0] slice_start;
        logic [15:0] slice_bytes;
        logic        last_fragment;
    } t_res;

    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [15:0] MAX_PAYLOAD = 16'd65515;
    localparam logic [15:0] MIN_LIMIT   = 16'd1032;
    localparam logic [15:0] LIMIT_RESET = 16'd1480;
    localparam logic [7:0]  TTL_VALUE   = 8'h10;
    localparam logic [15:0] VER_IHL_TOS = 16'h4500;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_TOT,
        S_FRAG,
        S_OUT
    } t_state;

    // Header words in the order the checksum adder visits them.
    typedef enum logic [3:0] {
        W_VER,
        W_ID,
        W_TTL,
        W_SRC_HI,
        W_SRC_LO,
        W_DST_HI,
        W_DST_LO,
        W_TOT,
        W_FRAG
    } t_word;

    typedef struct packed {
        logic  load;
        logic  sum_add;
        t_word word_sel;
        logic  out_frag;
        logic  out_err;
        logic  step;
    } t_cmd;

    typedef struct packed {
        logic in_too_large;
        logic in_empty;
        logic last;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/ifhg_ctrl.sv =====
`default_nettype none

module ifhg_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire ifhg_pkg::t_sts i_sts,
    output ifhg_pkg::t_cmd     o_cmd
);
    import ifhg_pkg::*;

    t_state r_state, n_state;
    t_word  r_word, n_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_word  <= W_VER;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state         = r_state;
        n_word          = r_word;
        o_cmd.load      = 1'b0;
        o_cmd.sum_add   = 1'b0;
        o_cmd.word_sel  = r_word;
        o_cmd.out_frag  = 1'b0;
        o_cmd.out_err   = 1'b0;
        o_cmd.step      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_too_large) begin
                        o_cmd.out_err = 1'b1;
                        n_state       = S_OUT;
                    end else if (!i_sts.in_empty) begin
                        n_state = S_BASE;
                        n_word  = W_VER;
                    end
                end
            end
            S_BASE: begin
                o_cmd.sum_add = 1'b1;
                if (r_word == W_DST_LO) begin
                    n_state = S_TOT;
                end else begin
                    n_word = t_word'(4'(r_word) + 4'd1);
                end
            end
            S_TOT: begin
                o_cmd.sum_add  = 1'b1;
                o_cmd.word_sel = W_TOT;
                n_state        = S_FRAG;
            end
            S_FRAG: begin
                o_cmd.sum_add  = 1'b1;
                o_cmd.word_sel = W_FRAG;
                o_cmd.out_frag = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_TOT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ifhg_dp.sv =====
`default_nettype none

module ifhg_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [15:0]    i_cfg_wdata,
    input  wire ifhg_pkg::t_req i_req,
    input  wire ifhg_pkg::t_cmd i_cmd,
    output ifhg_pkg::t_sts      o_sts,
    output ifhg_pkg::t_res      o_res
);
    import ifhg_pkg::*;

    // Ones'-complement add with the end-around carry folded back in.
    function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, acc} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    logic [15:0] r_limit_cfg;
    logic [15:0] r_ident;
    logic [15:0] r_id;
    logic [31:0] r_src;
    logic [31:0] r_dst;
    logic [7:0]  r_proto;
    logic [15:0] r_lim;
    logic [15:0] r_rem;
    logic [15:0] r_start;
    logic [15:0] r_base;
    logic [15:0] r_sum;
    t_res        r_res;

    logic [15:0] n_lim;
    logic        more;
    logic [15:0] bytes;
    logic [15:0] tot;
    logic [15:0] frag;
    logic [15:0] word;
    logic [15:0] acc;
    logic [15:0] n_fold;
    logic        too_large;

    assign too_large = (i_req.payload_length > MAX_PAYLOAD);

    always_comb begin
        n_lim = r_limit_cfg & 16'hFFF8;
        if (n_lim < MIN_LIMIT) begin
            n_lim = MIN_LIMIT;
        end
    end

    assign more  = (r_rem > r_lim);
    assign bytes = more ? r_lim : r_rem;
    assign tot   = HDR_BYTES + bytes;
    assign frag  = {2'b00, more, r_start[15:3]};

    always_comb begin
        case (i_cmd.word_sel)
            W_VER:    word = VER_IHL_TOS;
            W_ID:     word = r_id;
            W_TTL:    word = {TTL_VALUE, r_proto};
            W_SRC_HI: word = r_src[31:16];
            W_SRC_LO: word = r_src[15:0];
            W_DST_HI: word = r_dst[31:16];
            W_DST_LO: word = r_dst[15:0];
            W_TOT:    word = tot;
            W_FRAG:   word = frag;
            default:  word = '0;
        endcase
    end

    // The per-request part of the sum stays in r_base; each fragment
    // starts from it and adds its own length and offset words.
    assign acc    = (i_cmd.word_sel == W_FRAG) ? r_sum : r_base;
    assign n_fold = fold_add(acc, word);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_cfg <= LIMIT_RESET;
            r_ident     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit_cfg <= i_cfg_wdata;
            end
            if (i_cmd.load && !too_large) begin
                r_ident <= r_ident + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id    <= r_ident;
            r_src   <= i_req.source_address;
            r_dst   <= i_req.dest_address;
            r_proto <= i_req.protocol_number;
            r_lim   <= n_lim;
            r_rem   <= too_large ? 16'd0 : i_req.payload_length;
            r_start <= '0;
            r_base  <= '0;
        end
        if (i_cmd.sum_add) begin
            if (i_cmd.word_sel == W_TOT || i_cmd.word_sel == W_FRAG) begin
                r_sum <= n_fold;
            end else begin
                r_base <= n_fold;
            end
        end
        if (i_cmd.step) begin
            r_start <= r_start + bytes;
            r_rem   <= r_rem - bytes;
        end
        if (i_cmd.out_err) begin
            r_res.too_large       <= 1'b1;
            r_res.identification  <= '0;
            r_res.total_length    <= '0;
            r_res.more_fragments  <= 1'b0;
            r_res.fragment_offset <= '0;
            r_res.header_checksum <= '0;
            r_res.slice_start     <= '0;
            r_res.slice_bytes     <= '0;
            r_res.last_fragment   <= 1'b1;
        end
        if (i_cmd.out_frag) begin
            r_res.too_large       <= 1'b0;
            r_res.identification  <= r_id;
            r_res.total_length    <= tot;
            r_res.more_fragments  <= more;
            r_res.fragment_offset <= r_start[15:3];
            r_res.header_checksum <= ~n_fold;
            r_res.slice_start     <= r_start;
            r_res.slice_bytes     <= bytes;
            r_res.last_fragment   <= !more;
        end
    end

    assign o_sts.in_too_large = too_large;
    assign o_sts.in_empty     = (i_req.payload_length == 16'd0);
    assign o_sts.last         = r_res.last_fragment;
    assign o_res              = r_res;

endmodule

`default_nettype wire

// ===== rtl/ipv4_fragment_header_generator_top.sv =====
// IPv4 fragment header generator.
// A send request enters on the input channel (i_in_valid, o_in_stall,
// i_in_data) and produces zero or more result items on the output channel
// (o_out_valid, i_out_stall, o_out_data), one per fragment, in order of
// increasing offset, the last one marked by last_fragment.
// A request is taken only while the block is idle; one request is worked
// on at a time. An accepted request first sums the seven fixed header
// words, then each fragment adds its total length and fragment words on
// the shared checksum adder before its item appears in the output
// register. The next fragment is worked on only after the previous item
// is taken.
// A payload that is too large yields one error item in the cycle after
// acceptance; an empty payload yields nothing and the block is idle again
// in the next cycle.
// While the receiver stalls, the output item holds and the block waits.
// Reset (synchronous, active low) returns the block to idle, clears the
// identifier counter and sets the fragment limit register to 1480.
`default_nettype none

module ipv4_fragment_header_generator_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [15:0]    i_cfg_wdata,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire ifhg_pkg::t_req i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output ifhg_pkg::t_res      o_out_data
);
    import ifhg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller sequences the checksum words and the handshakes.
    ifhg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the request, the limit, the identifier counter,
    // the checksum accumulators and the output register.
    ifhg_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res      (o_out_data)
    );

endmodule

`default_nettype wire

// ===== test/tb_ipv4_fragment_header_generator_top.sv =====
`default_nettype none

module tb_ipv4_fragment_header_generator_top;

    import ifhg_pkg::*;

    // The whole run is bounded by this many clock cycles, far more than a
    // correct run needs, even if every request filled all 64 fragments under
    // the random stalls.
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    // After the last expected item the bench still gives the block this many
    // cycles before a register write or the end of the run.
    localparam int unsigned SETTLE_CYCLES = 20;

    // Cap on printed mismatch lines; every mismatch is still counted.
    localparam int unsigned PRINT_CAP = 100;

    // Scoreboard: holds the block's register and identifier counter, turns
    // every accepted request into the header items it must produce, and
    // compares the produced items against them in order.
    class header_scoreboard;
        t_res        expected_headers[$];
        logic [15:0] limit_reg;
        logic [15:0] next_ident;
        int unsigned failures;

        function new();
            limit_reg  = LIMIT_RESET;
            next_ident = '0;
            failures   = 0;
        endfunction

        function void set_limit(logic [15:0] value);
            limit_reg = value;
        endfunction

        // The low three bits of the register are dropped and the result is
        // raised to the floor, which keeps any request at 64 fragments or less.
        function logic [15:0] fragment_limit();
            logic [15:0] lim;
            lim = {limit_reg[15:3], 3'b000};
            if (lim < MIN_LIMIT) begin
                lim = MIN_LIMIT;
            end
            return lim;
        endfunction

        // Ones'-complement sum of the nine other header words, folded with
        // end-around carry, then inverted. The checksum word counts as zero.
        function logic [15:0] header_checksum(t_res hdr, t_req req);
            logic [31:0] sum;
            sum = 32'(VER_IHL_TOS) + 32'(hdr.total_length) + 32'(hdr.identification)
                + 32'({2'b00, hdr.more_fragments, hdr.fragment_offset})
                + 32'({TTL_VALUE, req.protocol_number})
                + 32'(req.source_address[31:16]) + 32'(req.source_address[15:0])
                + 32'(req.dest_address[31:16]) + 32'(req.dest_address[15:0]);
            sum = 32'(sum[15:0]) + 32'(sum[31:16]);
            sum = 32'(sum[15:0]) + 32'(sum[31:16]);
            return ~sum[15:0];
        endfunction

        // Splits one accepted request into its expected header items.
        function void note_request(t_req req);
            t_res        hdr;
            logic [15:0] lim;
            logic [15:0] ident;
            int unsigned remaining;
            int unsigned start;
            int unsigned bytes;
            if (req.payload_length > MAX_PAYLOAD) begin
                // An oversized payload gives one error item and keeps the
                // identifier counter where it is.
                hdr               = '0;
                hdr.too_large     = 1'b1;
                hdr.last_fragment = 1'b1;
                expected_headers.push_back(hdr);
                return;
            end
            ident      = next_ident;
            next_ident = next_ident + 16'd1;
            lim        = fragment_limit();
            remaining  = 32'(req.payload_length);
            start      = 0;
            while (remaining != 0) begin
                bytes                = (remaining > 32'(lim)) ? 32'(lim) : remaining;
                hdr                  = '0;
                hdr.identification   = ident;
                hdr.total_length     = 16'(32'(HDR_BYTES) + bytes);
                hdr.more_fragments   = (remaining > 32'(lim));
                hdr.fragment_offset  = 13'(start >> 3);
                hdr.slice_start      = 16'(start);
                hdr.slice_bytes      = 16'(bytes);
                hdr.last_fragment    = !hdr.more_fragments;
                hdr.header_checksum  = header_checksum(hdr, req);
                expected_headers.push_back(hdr);
                start     = start + bytes;
                remaining = remaining - bytes;
            end
        endfunction

        function int unsigned pending();
            return expected_headers.size();
        endfunction

        task report_mismatch(string msg);
            if (failures < PRINT_CAP) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            failures++;
        endtask

        task compare_field(string name, logic [31:0] got_v, logic [31:0] want_v,
                           t_res want);
            if (got_v !== want_v) begin
                report_mismatch($sformatf("%s got %0h want %0h (id %0h offset %0d)",
                                          name, got_v, want_v,
                                          want.identification,
                                          want.fragment_offset));
            end
        endtask

        task check_fragment(t_res got);
            t_res want;
            if (expected_headers.size() == 0) begin
                report_mismatch($sformatf("item %h with nothing expected", got));
                return;
            end
            want = expected_headers.pop_front();
            compare_field("too_large", 32'(got.too_large), 32'(want.too_large), want);
            compare_field("identification", 32'(got.identification),
                          32'(want.identification), want);
            compare_field("total_length", 32'(got.total_length),
                          32'(want.total_length), want);
            compare_field("more_fragments", 32'(got.more_fragments),
                          32'(want.more_fragments), want);
            compare_field("fragment_offset", 32'(got.fragment_offset),
                          32'(want.fragment_offset), want);
            compare_field("header_checksum", 32'(got.header_checksum),
                          32'(want.header_checksum), want);
            compare_field("slice_start", 32'(got.slice_start),
                          32'(want.slice_start), want);
            compare_field("slice_bytes", 32'(got.slice_bytes),
                          32'(want.slice_bytes), want);
            compare_field("last_fragment", 32'(got.last_fragment),
                          32'(want.last_fragment), want);
        endtask
    endclass

    // Every input of the block starts at a known value, reset held.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    t_req        i_in_data   = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_res        o_out_data;

    // When set, the sender inserts random gaps and the receiver stalls at
    // random; cleared for the stretches that run at full rate.
    bit          idling = 1'b1;

    int unsigned cycle_count = 0;

    header_scoreboard sb = new();

    ipv4_fragment_header_generator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Watchdog: a hung block or a lost item ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Receiver. Signals are sampled at the rising edge, so the stall seen here
    // is the one the block saw at the same edge. A new stall decision is then
    // driven for the next cycle.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_fragment(o_out_data);
            end
            i_out_stall <= idling && ($urandom_range(0, 99) < 28);
        end
    end

    function automatic t_req request_of(logic [15:0] len, logic [31:0] src,
                                        logic [31:0] dst, logic [7:0] proto);
        t_req req;
        req.payload_length  = len;
        req.source_address  = src;
        req.dest_address    = dst;
        req.protocol_number = proto;
        return req;
    endfunction

    function automatic t_req random_request(logic [15:0] len);
        return request_of(len, $urandom, $urandom, 8'($urandom_range(0, 255)));
    endfunction

    // Payload lengths for the random part: mostly a few fragments, some
    // exact multiples of the limit, a share over the whole legal range, a
    // few near the top, plus empty and oversized requests.
    function automatic logic [15:0] random_length(logic [15:0] lim);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            return '0;
        end
        if (pick < 12) begin
            return 16'($urandom_range(65516, 65535));
        end
        if (pick < 16) begin
            return 16'($urandom_range(60000, 65515));
        end
        if (pick < 30) begin
            return 16'($urandom_range(1, 65515));
        end
        if (pick < 40) begin
            return 16'(32'(lim) * $urandom_range(1, 65515 / 32'(lim)));
        end
        return 16'($urandom_range(1, 3000));
    endfunction

    // Offers one request and returns at the edge where it is accepted. Valid
    // stays high afterwards so that back-to-back requests need no bubble; the
    // next call may lower it and the drain does.
    task automatic send_request(t_req req);
        if (idling && ($urandom_range(0, 99) < 28)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_request(req);
    endtask

    // Holds the sender off until every expected item has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Register writes happen only with the block idle: everything drained,
    // then a settle time for requests that produce no item.
    task automatic write_limit(logic [15:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_limit(value);
    endtask

    task automatic random_phase(int unsigned count, bit drain_often);
        for (int unsigned n = 0; n < count; n++) begin
            send_request(random_request(random_length(sb.fragment_limit())));
            if (drain_often && (n % 40 == 39)) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset limit of 1480: empty payload with all
        // fields zero, one byte with all fields ones, exact multiples of the
        // limit, one past it, the largest legal payload, the two ends of the
        // oversized range, and payloads of eight and seven bytes.
        send_request(request_of(16'd0, '0, '0, '0));
        send_request(request_of(16'd1, '1, '1, '1));
        send_request(random_request(16'd1480));
        send_request(random_request(16'd1481));
        send_request(random_request(16'd2960));
        send_request(request_of(MAX_PAYLOAD, '1, '0, '1));
        send_request(random_request(16'd65516));
        send_request(random_request(16'd65535));
        send_request(random_request(16'd8));
        send_request(random_request(16'd7));

        // Smallest limit: the largest payload fills all 64 fragments.
        write_limit(MIN_LIMIT);
        send_request(random_request(MAX_PAYLOAD));
        send_request(random_request(16'd1032));
        send_request(random_request(16'd1033));

        // A register value below the floor behaves as the floor.
        write_limit(16'd0);
        send_request(random_request(16'd2064));
        send_request(random_request(16'd1));

        // All ones: the low bits are dropped, so the limit is 65528 and the
        // largest payload goes out as one fragment of total length 65535.
        write_limit(16'hFFFF);
        send_request(random_request(MAX_PAYLOAD));
        send_request(random_request(16'd65528));
        write_limit(16'd65528);
        send_request(random_request(16'd1000));

        // Low bits ignored near the floor: 1039 acts as 1032.
        write_limit(16'd1039);
        send_request(random_request(16'd1039));
        send_request(random_request(16'd1040));

        // A short burst at full rate: empty payloads back to back, then a
        // few small requests.
        wait_drained();
        idling = 1'b0;
        repeat (8) send_request(random_request(16'd0));
        repeat (3) send_request(random_request(16'($urandom_range(1, 3000))));
        idling = 1'b1;

        // Random part in several register settings. The second phase pauses
        // the sender now and then until the block has drained; the third runs
        // without any idling on either side.
        write_limit(16'($urandom_range(0, 65535)));
        random_phase(100, 1'b0);
        write_limit(MIN_LIMIT);
        random_phase(100, 1'b1);
        write_limit(16'($urandom_range(1032, 4000)));
        idling = 1'b0;
        random_phase(100, 1'b0);
        wait_drained();
        idling = 1'b1;
        write_limit(LIMIT_RESET);
        random_phase(100, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
